// ===== hw/rtl/reversible_ring_deque_assert.svh =====
// Assertion helpers for the ring deque.
// Each use samples on clk and is off while arst_n is low.
`ifndef REVERSIBLE_RING_DEQUE_ASSERT_SVH
`define REVERSIBLE_RING_DEQUE_ASSERT_SVH

// Same-cycle implication.
`define RRD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define RRD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/rrd_pkg.sv =====
package rrd_pkg;

	// Command codes
	localparam logic [2:0] CMD_CLEAR   = 3'd0;
	localparam logic [2:0] CMD_LOAD    = 3'd1;
	localparam logic [2:0] CMD_REVERSE = 3'd2;
	localparam logic [2:0] CMD_DELETE  = 3'd3;
	localparam logic [2:0] CMD_TAKE    = 3'd4;

	// Status codes
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_DEL_EMPTY  = 3'd1;
	localparam logic [2:0] ST_LOAD_FULL  = 3'd2;
	localparam logic [2:0] ST_REFUSED    = 3'd3;
	localparam logic [2:0] ST_TAKE_EMPTY = 3'd4;

	localparam int unsigned COUNT_W = 11;

	// Request beat
	typedef struct packed {
		logic [2:0]         command;
		logic signed [31:0] value;
	} rrd_req_t;

	// Response beat
	typedef struct packed {
		logic signed [31:0]   data_out;
		logic                 data_valid;
		logic [2:0]           status;
		logic [COUNT_W-1:0]   entry_count;
	} rrd_rsp_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;       // request beat taken this cycle
		logic finish_take;  // read data is ready, build the take response
	} rrd_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic rsp_busy;     // response register full and not draining
		logic take_pop;     // current request is a take that pops a word
	} rrd_stat_t;

endpackage

// ===== hw/rtl/rrd_ctrl.sv =====
module rrd_ctrl
	import rrd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  rrd_stat_t stat,
	output rrd_cmd_t  cmd
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_READ = 2'b10
	} state_t;

	state_t state_q, state_n;

	// Accept only when idle and the response register can take a result
	assign req_ready       = (state_q == S_IDLE) && !stat.rsp_busy;
	assign cmd.accept      = req_valid && req_ready;
	assign cmd.finish_take = (state_q == S_READ);

	// Next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.accept && stat.take_pop) begin
					state_n = S_READ;
				end
			end
			S_READ: begin
				state_n = S_IDLE;
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

endmodule

// ===== hw/rtl/rrd_datapath.sv =====
module rrd_datapath
	import rrd_pkg::*;
#(
	parameter int unsigned DEPTH = 1024
) (
	input  logic      clk,
	input  logic      arst_n,
	input  rrd_req_t  req_data,
	input  rrd_cmd_t  cmd,
	output rrd_stat_t stat,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rrd_rsp_t  rsp_data
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	// Word store, one write and one registered read port
	logic [31:0] store_q [DEPTH];
	logic [31:0] rd_data_q;

	logic [AW-1:0] front_q, back_q, front_n, back_n;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [CW-1:0] count_q, count_n;
	logic          rev_q, rev_n, err_q, err_n;
	logic          wr_en, rd_en, take_pop;
	logic [2:0]    status;
	logic          full, empty;
	logic          rsp_valid_q;
	rrd_rsp_t      rsp_q;

	logic [CW+COUNT_W-1:0] count_n_wide, count_q_wide;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);

	assign count_n_wide = {{COUNT_W{1'b0}}, count_n};
	assign count_q_wide = {{COUNT_W{1'b0}}, count_q};

	// Command decode and next state
	always_comb begin
		front_n  = front_q;
		back_n   = back_q;
		count_n  = count_q;
		rev_n    = rev_q;
		err_n    = err_q;
		wr_en    = 1'b0;
		wr_addr  = front_q;
		rd_addr  = front_q;
		take_pop = 1'b0;
		status   = ST_OK;
		unique case (req_data.command)
			CMD_CLEAR: begin
				front_n = '0;
				back_n  = '0;
				count_n = '0;
				rev_n   = 1'b0;
				err_n   = 1'b0;
			end
			CMD_LOAD: begin
				if (full) begin
					status = ST_LOAD_FULL;
				end else begin
					front_n = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
					wr_addr = front_n;
					wr_en   = 1'b1;
					count_n = count_q + CW'(1);
				end
			end
			CMD_REVERSE: begin
				rev_n = !rev_q;
			end
			CMD_DELETE, CMD_TAKE: begin
				if (err_q) begin
					status = ST_REFUSED;
				end else if (empty) begin
					if (req_data.command == CMD_DELETE) begin
						err_n  = 1'b1;
						status = ST_DEL_EMPTY;
					end else begin
						status = ST_TAKE_EMPTY;
					end
				end else begin
					// Pop from the logical head
					if (rev_q) begin
						rd_addr = front_q;
						front_n = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + AW'(1);
					end else begin
						back_n  = (back_q == '0) ? AW'(DEPTH - 1) : back_q - AW'(1);
						rd_addr = back_n;
					end
					count_n  = count_q - CW'(1);
					take_pop = (req_data.command == CMD_TAKE);
				end
			end
			default: begin
			end
		endcase
	end

	assign rd_en = cmd.accept && take_pop;

	assign stat.take_pop = take_pop;
	assign stat.rsp_busy = rsp_valid_q && !rsp_ready;

	// Pointer, count and flag registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			back_q  <= '0;
			count_q <= '0;
			rev_q   <= 1'b0;
			err_q   <= 1'b0;
		end else if (cmd.accept) begin
			front_q <= front_n;
			back_q  <= back_n;
			count_q <= count_n;
			rev_q   <= rev_n;
			err_q   <= err_n;
		end
	end

	// Store access
	always_ff @(posedge clk) begin
		if (cmd.accept && wr_en) begin
			store_q[wr_addr] <= req_data.value;
		end
		if (rd_en) begin
			rd_data_q <= store_q[rd_addr];
		end
	end

	// Response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((cmd.accept && !take_pop) || cmd.finish_take) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Response payload
	always_ff @(posedge clk) begin
		if (cmd.accept && !take_pop) begin
			rsp_q.data_out    <= '0;
			rsp_q.data_valid  <= 1'b0;
			rsp_q.status      <= status;
			rsp_q.entry_count <= count_n_wide[COUNT_W-1:0];
		end else if (cmd.finish_take) begin
			rsp_q.data_out    <= rd_data_q;
			rsp_q.data_valid  <= 1'b1;
			rsp_q.status      <= ST_OK;
			rsp_q.entry_count <= count_q_wide[COUNT_W-1:0];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

// ===== hw/rtl/reversible_ring_deque.sv =====
// Channel  Handshake             Payload     Beat
// req      req_valid/req_ready   rrd_req_t   one command
// rsp      rsp_valid/rsp_ready   rrd_rsp_t   one result per command
//
// Clear, load, reverse, delete and refused or empty takes: a new beat can follow while the response drains.
// A take that pops a word goes through the registered read of the store; no beat is taken until it finishes.
// Reset clears pointers, count and flags at once; the store needs no clearing.
// A request is taken while the response register is empty or draining and no popping take is pending.
`include "reversible_ring_deque_assert.svh"

module reversible_ring_deque
	import rrd_pkg::*;
#(
	parameter int unsigned DEPTH = 1024
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  rrd_req_t req_data,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output rrd_rsp_t rsp_data
);

	rrd_cmd_t  ctrl_cmd;
	rrd_stat_t dp_stat;

	rrd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.stat      (dp_stat),
		.cmd       (ctrl_cmd)
	);

	rrd_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req_data),
		.cmd       (ctrl_cmd),
		.stat      (dp_stat),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

	// No new beat while a read is pending
	`RRD_ASSERT_NOW(a_no_accept_in_read, ctrl_cmd.finish_take, !req_ready, "request taken during read")
	// A popping take finishes the next cycle
	`RRD_ASSERT_NEXT(a_take_finishes, ctrl_cmd.accept && dp_stat.take_pop, ctrl_cmd.finish_take, "take read not finished")
	// A finished take presents valid data
	`RRD_ASSERT_NEXT(a_take_result, ctrl_cmd.finish_take, rsp_valid && rsp_data.data_valid, "take result missing")

endmodule

// ===== tb/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rrd_pkg::*;

	localparam int unsigned DEPTH = 1024;
	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned HOLD_AT = 40;       // responses seen before the long stall
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned MAX_PRINTS = 100;

	// Command codes with no function in the block
	localparam logic [2:0] CMD_UNUSED_MIN = 3'd5;
	localparam logic [2:0] CMD_UNUSED_MAX = 3'd7;

	// Idle percentages per traffic phase: sender-heavy, receiver-heavy, none
	localparam int unsigned SEND_IDLE_PCT[3] = '{29, 57, 0};
	localparam int unsigned RECV_IDLE_PCT[3] = '{57, 29, 0};

	typedef struct {
		rrd_req_t    req;
		bit          drain;     // hold this beat until all responses are back
		int unsigned phase;
	} stim_beat_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_ready;
	rrd_req_t req_data = '0;
	logic     rsp_valid;
	logic     rsp_ready = 1'b0;
	rrd_rsp_t rsp_data;

	stim_beat_t  stim_q[$];
	rrd_rsp_t    expected_rsp[$];
	int unsigned beats_sent = 0;
	int unsigned beats_seen = 0;
	int unsigned cur_phase = 0;
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;

	// Deque mirror used to predict responses
	logic [31:0]      mirror_mem [DEPTH];
	logic [PTR_W-1:0] mirror_front = '0;
	logic [PTR_W-1:0] mirror_back = '0;
	int unsigned      mirror_count = 0;
	bit               mirror_rev = 1'b0;
	bit               mirror_err = 1'b0;

	// Stimulus generator bookkeeping
	int unsigned gen_phase = 0;
	int unsigned gen_live = 0;

	reversible_ring_deque #(
		.DEPTH(DEPTH)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	task automatic flag_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_PRINTS) begin
			$display("[%0t] mismatch: %s", $realtime, msg);
		end
	endtask

	// Apply one command to the mirror and return the response it should produce
	function automatic rrd_rsp_t deque_step(rrd_req_t req);
		rrd_rsp_t    rsp;
		logic [31:0] word;
		rsp = '0;
		rsp.status = ST_OK;
		case (req.command)
			CMD_CLEAR: begin
				mirror_front = '0;
				mirror_back = '0;
				mirror_count = 0;
				mirror_rev = 1'b0;
				mirror_err = 1'b0;
			end
			CMD_LOAD: begin
				if (mirror_count >= DEPTH) begin
					rsp.status = ST_LOAD_FULL;
				end else begin
					// power-of-two depth: pointers wrap on their own
					mirror_front = mirror_front - 1'b1;
					mirror_mem[mirror_front] = req.value;
					mirror_count++;
				end
			end
			CMD_REVERSE: begin
				mirror_rev = !mirror_rev;
			end
			CMD_DELETE, CMD_TAKE: begin
				if (mirror_err) begin
					rsp.status = ST_REFUSED;
				end else if (mirror_count == 0) begin
					if (req.command == CMD_DELETE) begin
						mirror_err = 1'b1;
						rsp.status = ST_DEL_EMPTY;
					end else begin
						rsp.status = ST_TAKE_EMPTY;
					end
				end else begin
					// head is the front end when reversed, else the back end
					if (mirror_rev) begin
						word = mirror_mem[mirror_front];
						mirror_front = mirror_front + 1'b1;
					end else begin
						mirror_back = mirror_back - 1'b1;
						word = mirror_mem[mirror_back];
					end
					mirror_count--;
					if (req.command == CMD_TAKE) begin
						rsp.data_out = word;
						rsp.data_valid = 1'b1;
					end
				end
			end
			default: ;
		endcase
		rsp.entry_count = COUNT_W'(mirror_count);
		return rsp;
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return 32'h0000_0000;
			default: return $urandom;
		endcase
	endfunction

	task automatic add_beat(input logic [2:0] cmd, input logic [31:0] word, input bit drain = 0);
		stim_beat_t b;
		b.req.command = cmd;
		b.req.value = word;
		b.drain = drain;
		b.phase = gen_phase;
		stim_q = {stim_q, b};
	endtask

	// One burst of traffic, mostly opened by a clear, optionally after earlier responses have drained
	task automatic add_session(input bit drain);
		int unsigned n;
		int unsigned pick;
		if ($urandom_range(7) != 0) begin
			add_beat(CMD_CLEAR, rand_word(), drain);
			gen_live = 0;
		end else begin
			add_beat(CMD_REVERSE, rand_word(), drain);
		end
		n = $urandom_range(6, 40);
		repeat (n) begin
			pick = $urandom_range(99);
			if (pick < 45) begin
				add_beat(CMD_LOAD, rand_word());
				if (gen_live < DEPTH) gen_live++;
			end else if (pick < 70) begin
				add_beat(CMD_TAKE, rand_word());
				if (gen_live > 0) gen_live--;
			end else if (pick < 80) begin
				if (gen_live > 0) begin
					add_beat(CMD_DELETE, rand_word());
					gen_live--;
				end else if ($urandom_range(3) == 0) begin
					add_beat(CMD_DELETE, rand_word());
				end else begin
					add_beat(CMD_LOAD, rand_word());
					gen_live++;
				end
			end else if (pick < 92) begin
				add_beat(CMD_REVERSE, rand_word());
			end else if (pick < 96) begin
				add_beat(3'($urandom_range(CMD_UNUSED_MIN, CMD_UNUSED_MAX)), rand_word());
			end else begin
				add_beat(CMD_CLEAR, rand_word());
				gen_live = 0;
			end
		end
		// read out what is left, sometimes one past empty
		if ($urandom_range(1) == 0) begin
			repeat (gen_live) add_beat(CMD_TAKE, rand_word());
			gen_live = 0;
			if ($urandom_range(2) == 0) add_beat(CMD_TAKE, rand_word());
		end
	endtask

	initial begin
		// directed: empty cases, error latch, extremes, both pop ends, spare codes
		add_beat(CMD_TAKE, 32'h0);
		add_beat(CMD_DELETE, 32'hffff_ffff);
		add_beat(CMD_TAKE, 32'h0);
		add_beat(CMD_DELETE, 32'h0);
		add_beat(CMD_LOAD, 32'h7fff_ffff);
		add_beat(CMD_REVERSE, 32'h0);
		add_beat(CMD_TAKE, 32'h0);
		add_beat(CMD_UNUSED_MIN, 32'hffff_ffff);
		add_beat(CMD_UNUSED_MIN + 3'd1, 32'h1234_5678);
		add_beat(CMD_UNUSED_MAX, 32'h8000_0000);
		add_beat(CMD_CLEAR, 32'hffff_ffff);
		add_beat(CMD_LOAD, 32'h8000_0000);
		add_beat(CMD_LOAD, 32'hffff_ffff);
		add_beat(CMD_LOAD, 32'h0000_0000);
		add_beat(CMD_LOAD, 32'h7fff_ffff);
		add_beat(CMD_TAKE, 32'h0);
		add_beat(CMD_REVERSE, 32'h0);
		add_beat(CMD_TAKE, 32'h0);
		add_beat(CMD_DELETE, 32'h0);
		add_beat(CMD_REVERSE, 32'h0);
		add_beat(CMD_TAKE, 32'h0);
		add_beat(CMD_TAKE, 32'h0);
		add_beat(CMD_LOAD, 32'h5555_5555);
		add_beat(CMD_LOAD, 32'haaaa_aaaa);
		add_beat(CMD_CLEAR, 32'h0);
		gen_live = 0;

		// random sessions across the three idle phases
		add_session(1'b1);
		while (stim_q.size() < 260) add_session($urandom_range(4) == 0);
		gen_phase = 1;
		add_session(1'b1);
		while (stim_q.size() < 520) add_session($urandom_range(4) == 0);
		gen_phase = 2;
		add_session(1'b1);
		while (stim_q.size() < 740) add_session($urandom_range(4) == 0);

		// pop from both ends across reversals, then run past empty
		add_beat(CMD_CLEAR, rand_word(), 1'b1);
		repeat (12) add_beat(CMD_LOAD, rand_word());
		add_beat(CMD_REVERSE, rand_word());
		repeat (5) add_beat(CMD_TAKE, rand_word());
		repeat (6) add_beat(CMD_LOAD, rand_word());
		add_beat(CMD_REVERSE, rand_word());
		repeat (10) begin
			add_beat(CMD_TAKE, rand_word());
			add_beat(CMD_DELETE, rand_word());
		end
		add_beat(CMD_CLEAR, rand_word());
		gen_live = 0;
		repeat (4) add_session($urandom_range(1) == 0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		do @(negedge clk);
		while (stim_q.size() != 0 || req_valid || beats_sent != beats_seen);
		repeat (10) @(posedge clk);

		if (expected_rsp.size() != 0) begin
			flag_mismatch($sformatf("%0d responses never arrived", expected_rsp.size()));
		end
		if (mismatches == 0) begin
			$display("PASS reversible_ring_deque");
		end else begin
			$display("FAIL reversible_ring_deque");
		end
		$finish;
	end

	// Request driver
	always @(posedge clk or negedge arst_n) begin : driver
		int in_flight;
		stim_beat_t b;
		if (!arst_n) begin
			req_valid <= 1'b0;
			req_data <= '0;
			beats_sent <= 0;
		end else begin
			in_flight = int'(beats_sent) + int'(req_valid && req_ready)
				- int'(beats_seen) - int'(rsp_valid && rsp_ready);
			if (req_valid && req_ready) beats_sent <= beats_sent + 1;
			if (!req_valid || req_ready) begin
				if (stim_q.size() == 0) begin
					req_valid <= 1'b0;
				end else if (stim_q[0].drain && in_flight != 0) begin
					req_valid <= 1'b0;
				end else if ($urandom_range(99) < SEND_IDLE_PCT[stim_q[0].phase]) begin
					req_valid <= 1'b0;
				end else begin
					b = stim_q[0];
					stim_q.delete(0);
					req_valid <= 1'b1;
					req_data <= b.req;
					cur_phase <= b.phase;
				end
			end
		end
	end

	// Response sink: random back-pressure, and one long stall early on
	always @(posedge clk or negedge arst_n) begin : sink
		int unsigned hold_left;
		bit hold_done;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			hold_left = 0;
			hold_done = 1'b0;
		end else if (!hold_done && beats_seen >= HOLD_AT) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			rsp_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(99) >= RECV_IDLE_PCT[cur_phase]);
		end
	end

	// Monitor: predict on each request beat, check each response beat
	always @(posedge clk or negedge arst_n) begin : monitor
		rrd_rsp_t want;
		if (!arst_n) begin
			beats_seen <= 0;
		end else begin
			if (req_valid && req_ready) expected_rsp = {expected_rsp, deque_step(req_data)};
			if (rsp_valid && rsp_ready) begin
				beats_seen <= beats_seen + 1;
				if (expected_rsp.size() == 0) begin
					flag_mismatch("response beat with nothing expected");
				end else begin
					want = expected_rsp[0];
					expected_rsp.delete(0);
					if (rsp_data.data_out !== want.data_out) begin
						flag_mismatch($sformatf("beat %0d data_out %h, expected %h",
							beats_seen, rsp_data.data_out, want.data_out));
					end
					if (rsp_data.data_valid !== want.data_valid) begin
						flag_mismatch($sformatf("beat %0d data_valid %b, expected %b",
							beats_seen, rsp_data.data_valid, want.data_valid));
					end
					if (rsp_data.status !== want.status) begin
						flag_mismatch($sformatf("beat %0d status %0d, expected %0d",
							beats_seen, rsp_data.status, want.status));
					end
					if (rsp_data.entry_count !== want.entry_count) begin
						flag_mismatch($sformatf("beat %0d entry_count %0d, expected %0d",
							beats_seen, rsp_data.entry_count, want.entry_count));
					end
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL reversible_ring_deque");
			$finish;
		end
	end

endmodule
